/* hdl/lsmr_pkg.sv */
// shared types, constants and helper functions for the line sensor message
// parser and recovery tracker; no dependencies
`default_nettype none

package lsmr_pkg;

  localparam int unsigned VAL_W        = 14;
  localparam int unsigned TICK_W       = 32;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned REG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned IN_TUSER_W   = 1;
  localparam int unsigned MIN_LINE_BYTES = 25;
  localparam int unsigned POS_MAX      = 31;
  localparam logic [7:0]  CHAR_LF      = 8'd10;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ACTIVATE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEACTIVATE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DATA_TO    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RECOV_TO   = 2'd3;

  // input kinds carried on tuser
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [1:0] {
    FLD_L   = 2'd0,
    FLD_C   = 2'd1,
    FLD_R   = 2'd2,
    FLD_LIT = 2'd3
  } field_sel_t;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_ENDED  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DIR_LINE    = 2'd0,
    DIR_LEFT    = 2'd1,
    DIR_RIGHT   = 2'd2,
    DIR_TIMEOUT = 2'd3
  } dir_t;

  // end-of-line report from the parser, fields in message order
  typedef struct packed {
    logic             eol;
    logic             ok;
    logic [VAL_W-1:0] msg_l;
    logic [VAL_W-1:0] msg_c;
    logic [VAL_W-1:0] msg_r;
  } line_info_t;

  // result item, lowest bit last
  typedef struct packed {
    logic             message_rejected;
    logic             message_accepted;
    logic             recovery_active;
    dir_t             recovery_direction;
    logic             right_detected;
    logic             center_detected;
    logic             left_detected;
    logic [VAL_W-1:0] right_value;
    logic [VAL_W-1:0] center_value;
    logic [VAL_W-1:0] left_value;
    logic             data_valid;
  } result_t;

  localparam int unsigned RESULT_W    = $bits(result_t);
  localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - RESULT_W;

  function automatic field_sel_t field_of(input logic [POS_W-1:0] pos);
    field_sel_t f;
    if (pos < 5'd3)       f = FLD_LIT;
    else if (pos < 5'd7)  f = FLD_L;
    else if (pos < 5'd12) f = FLD_LIT;
    else if (pos < 5'd16) f = FLD_C;
    else if (pos < 5'd21) f = FLD_LIT;
    else                  f = FLD_R;
    return f;
  endfunction

  // expected literal byte of "l: 0000, c: 0000, r: 0000"
  function automatic logic [7:0] lit_char(input logic [POS_W-1:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:    ch = 8'h6C;
      5'd1:    ch = 8'h3A;
      5'd2:    ch = 8'h20;
      5'd7:    ch = 8'h2C;
      5'd8:    ch = 8'h20;
      5'd9:    ch = 8'h63;
      5'd10:   ch = 8'h3A;
      5'd11:   ch = 8'h20;
      5'd16:   ch = 8'h2C;
      5'd17:   ch = 8'h20;
      5'd18:   ch = 8'h72;
      5'd19:   ch = 8'h3A;
      5'd20:   ch = 8'h20;
      default: ch = 8'h30;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'd48) && (b <= 8'd57);
  endfunction

endpackage

`default_nettype wire

/* hdl/lsmr_parser.sv */
// positional line parser: checks the literal text and gathers the three
// number fields; depends on lsmr_pkg
`default_nettype none

module lsmr_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic                  mode,
  input  wire logic [7:0]            rx_byte,
  output lsmr_pkg::line_info_t       line_info
);
  import lsmr_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             fok_r, fok_nxt;
  phase_t           phase_r [3];
  phase_t           phase_nxt [3];
  logic [VAL_W-1:0] acc_r [3];
  logic [VAL_W-1:0] acc_nxt [3];
  field_sel_t       fsel;
  logic [1:0]       fidx;
  logic             eol;
  logic [VAL_W-1:0] digit_val;

  assign fsel      = field_of(pos_r);
  assign fidx      = fsel;
  assign eol       = (rx_byte == CHAR_LF);
  assign digit_val = {{(VAL_W-4){1'b0}}, rx_byte[3:0]};

  always_comb begin
    fok_nxt   = fok_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    if (pos_r < POS_W'(MIN_LINE_BYTES)) begin
      if (fsel == FLD_LIT) begin
        if (rx_byte != lit_char(pos_r)) fok_nxt = 1'b0;
      end else begin
        case (phase_r[fidx])
          PH_LEAD: begin
            if (is_digit(rx_byte)) begin
              acc_nxt[fidx]   = digit_val;
              phase_nxt[fidx] = PH_DIGITS;
            end else if (!is_space(rx_byte)) begin
              fok_nxt = 1'b0;
            end
          end
          PH_DIGITS: begin
            if (is_digit(rx_byte)) begin
              // times ten as two shifts, kept to the field width
              acc_nxt[fidx] = (acc_r[fidx] << 3) + (acc_r[fidx] << 1) + digit_val;
            end else begin
              phase_nxt[fidx] = PH_ENDED;
            end
          end
          default: ;
        endcase
      end
    end
    pos_nxt = (pos_r != POS_W'(POS_MAX)) ? pos_r + 1'b1 : pos_r;
  end

  assign line_info.eol   = (mode == MODE_BYTE) && eol;
  assign line_info.ok    = fok_nxt && (pos_r >= POS_W'(MIN_LINE_BYTES - 1)) &&
                           (phase_nxt[0] != PH_LEAD) && (phase_nxt[1] != PH_LEAD) &&
                           (phase_nxt[2] != PH_LEAD);
  assign line_info.msg_l = acc_nxt[0];
  assign line_info.msg_c = acc_nxt[1];
  assign line_info.msg_r = acc_nxt[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fok_r <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        phase_r[i] <= PH_LEAD;
        acc_r[i]   <= '0;
      end
    end else if (step && mode == MODE_BYTE) begin
      if (eol) begin
        pos_r <= '0;
        fok_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          phase_r[i] <= PH_LEAD;
          acc_r[i]   <= '0;
        end
      end else begin
        pos_r   <= pos_nxt;
        fok_r   <= fok_nxt;
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/lsmr_tracker.sv */
// configuration registers, stored sample, staleness and recovery tracking,
// and forming of the result item; depends on lsmr_pkg
`default_nettype none

module lsmr_tracker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                step,
  input  wire logic                                mode,
  input  wire lsmr_pkg::line_info_t                line_info,
  input  wire logic                                cfg_we,
  input  wire logic [lsmr_pkg::REG_IDX_W-1:0]      cfg_idx,
  input  wire logic [lsmr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output lsmr_pkg::result_t                        result
);
  import lsmr_pkg::*;

  logic [VAL_W-1:0]  act_r, deact_r;
  logic [TICK_W-1:0] dto_r, rto_r;
  logic [VAL_W-1:0]  vals_r [3];
  logic [VAL_W-1:0]  vals_nxt [3];
  logic              have_r, have_nxt;
  logic [TICK_W-1:0] tsu_r, tsu_nxt, tsl_r, tsl_nxt;
  dir_t              dir_r, dir_nxt;
  logic              take;
  logic              valid;

  assign take = (mode == MODE_BYTE) && line_info.eol && line_info.ok;

  always_comb begin
    vals_nxt = vals_r;
    have_nxt = have_r;
    tsu_nxt  = tsu_r;
    tsl_nxt  = tsl_r;
    dir_nxt  = dir_r;
    if (mode == MODE_TICK) begin
      if (tsu_r != '1) tsu_nxt = tsu_r + 1'b1;
      if (tsl_r != '1) tsl_nxt = tsl_r + 1'b1;
    end else if (take) begin
      // direction from the sample held before this line
      if (have_r) begin
        if (vals_r[0] <= deact_r && vals_r[2] > deact_r) dir_nxt = DIR_LEFT;
        else if (vals_r[2] <= deact_r && vals_r[0] > deact_r) dir_nxt = DIR_RIGHT;
      end
      vals_nxt[0] = line_info.msg_r;
      vals_nxt[1] = line_info.msg_c;
      vals_nxt[2] = line_info.msg_l;
      if (line_info.msg_r < deact_r || line_info.msg_c < deact_r ||
          line_info.msg_l < deact_r) begin
        dir_nxt = DIR_LINE;
        tsl_nxt = '0;
      end
      tsu_nxt  = '0;
      have_nxt = 1'b1;
    end
    if (tsl_nxt > rto_r) dir_nxt = DIR_TIMEOUT;
  end

  assign valid = have_nxt && (tsu_nxt <= dto_r);

  always_comb begin
    result.data_valid         = valid;
    result.left_value         = valid ? vals_nxt[0] : '0;
    result.center_value       = valid ? vals_nxt[1] : '0;
    result.right_value        = valid ? vals_nxt[2] : '0;
    result.left_detected      = valid && (vals_nxt[0] < act_r);
    result.center_detected    = valid && (vals_nxt[1] < act_r);
    result.right_detected     = valid && (vals_nxt[2] < act_r);
    result.recovery_direction = dir_nxt;
    result.recovery_active    = (dir_nxt == DIR_LEFT) || (dir_nxt == DIR_RIGHT);
    result.message_accepted   = take;
    result.message_rejected   = (mode == MODE_BYTE) && line_info.eol && !line_info.ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= '0;
      deact_r <= '0;
      dto_r   <= TICK_W'(100);
      rto_r   <= TICK_W'(1000);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ACTIVATE:   act_r   <= cfg_wdata[VAL_W-1:0];
        REG_DEACTIVATE: deact_r <= cfg_wdata[VAL_W-1:0];
        REG_DATA_TO:    dto_r   <= cfg_wdata[TICK_W-1:0];
        REG_RECOV_TO:   rto_r   <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) vals_r[i] <= '0;
      have_r <= 1'b0;
      tsu_r  <= '0;
      tsl_r  <= '0;
      dir_r  <= DIR_TIMEOUT;
    end else if (step) begin
      vals_r <= vals_nxt;
      have_r <= have_nxt;
      tsu_r  <= tsu_nxt;
      tsl_r  <= tsl_nxt;
      dir_r  <= dir_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/line_sensor_message_and_recovery.sv */
// top level of the line sensor message parser and recovery tracker
// depends on lsmr_pkg, lsmr_parser and lsmr_tracker
//
// usage:
//   in_*  : one item per transfer; in_tuser is the kind (0 received byte,
//           1 time tick), in_tdata the byte. lines end with byte 10.
//   out_* : exactly one result per input item, in order.
//   cfg_* : register writes (index 0 activate threshold, 1 deactivate
//           threshold, 2 data timeout ticks, 3 recovery timeout ticks); always
//           ready; user must write only while the block is idle; not enforced.
// path: the input register, then parse and tracking logic into the output
//   register, which drives out_tvalid.
// throughput: one item per cycle while out_tready allows; set by the single
//   update of line and tracking state per item in the result-register cycle.
// reset: rst_n low clears the line in progress, stored sample, counters
//   and sets the recovery direction to timed out; registers take their
//   defaults (thresholds 0, timeouts 100 and 1000).
// stall: while out_tready is low the result holds, the input register
//   keeps one more item and in_tready drops only when both are full.
`default_nettype none

module line_sensor_message_and_recovery (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  input  wire logic [lsmr_pkg::IN_TDATA_W-1:0]     in_tdata,   // rx_byte
  input  wire logic [lsmr_pkg::IN_TUSER_W-1:0]     in_tuser,   // mode
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  // data_valid, left_value, center_value, right_value, left_detected,
  // center_detected, right_detected, recovery_direction, recovery_active,
  // message_accepted, message_rejected, zero fill
  output      logic [lsmr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [lsmr_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [lsmr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lsmr_pkg::*;

  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [7:0] s1_byte_r;
  logic       s1_adv;
  logic       step;
  logic       out_valid_r;
  result_t    res_r;
  result_t    result;
  line_info_t line_info;

  assign s1_adv    = !out_valid_r || out_tready;
  assign step      = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r <= in_tuser[0];
      s1_byte_r <= in_tdata;
    end
  end

  lsmr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .mode      (s1_mode_r),
    .rx_byte   (s1_byte_r),
    .line_info (line_info)
  );

  lsmr_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .mode      (s1_mode_r),
    .line_info (line_info),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .result    (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, res_r};

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.message_accepted && res_r.message_rejected))
    else $error("line both accepted and rejected");

  a_stale_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.data_valid) |->
      (res_r.left_value == '0 && res_r.center_value == '0 &&
       res_r.right_value == '0 && !res_r.left_detected &&
       !res_r.center_detected && !res_r.right_detected))
    else $error("stale result carries readings");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages full");

  a_accept_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (step && result.message_accepted && !$isunknown(res_r)) |=>
      (res_r.data_valid || $past(result.data_valid) == 1'b0))
    else $error("accepted line lost its sample");

endmodule

`default_nettype wire
